// ===== hdl/jwrd_pkg.sv =====
// Jog wheel report decoder package: report offsets, thresholds, queue record type
// and the wrap-aware tick delta function. No dependencies.
package jwrd_pkg;

    localparam int unsigned JWRD_MAX_REPORT_BYTES = 256;
    localparam int unsigned JWRD_QUEUE_DEPTH      = 2;

    localparam int unsigned JWRD_MIN_REPORT_LEN = 10;
    localparam int unsigned JWRD_OFF_ID         = 0;
    localparam int unsigned JWRD_OFF_TICK_L     = 1;
    localparam int unsigned JWRD_OFF_TICK_R     = 5;
    localparam int unsigned JWRD_OFF_FADER_LO   = 7;
    localparam int unsigned JWRD_OFF_FADER_HI   = 8;
    localparam int unsigned JWRD_OFF_PLAY_B     = 'hc;
    localparam int unsigned JWRD_OFF_PLAY_A     = 'hd;
    localparam int unsigned JWRD_OFF_TOUCH      = 'h11;

    localparam logic [7:0]  JWRD_SHORT_ID   = 8'd1;
    localparam logic [7:0]  JWRD_TICK_HIGH  = 8'd200;
    localparam logic [7:0]  JWRD_TICK_LOW   = 8'd100;
    localparam logic signed [9:0] JWRD_TICK_SPAN = 10'sd256;
    localparam logic [15:0] JWRD_FADER_BIAS = 16'd2048;

    localparam logic JWRD_KIND_SHORT = 1'b0;
    localparam logic JWRD_KIND_LONG  = 1'b1;

    // one completed report, as handed from front to back
    typedef struct packed {
        logic        short_rpt;
        logic [7:0]  tick_l;
        logic [7:0]  tick_r;
        logic [15:0] fader_word;
        logic        start;
        logic [1:0]  touch;
    } jwrd_rec_t;

    function automatic logic signed [9:0] jwrd_tick_delta(input logic [7:0] prev,
                                                          input logic [7:0] now);
        logic signed [9:0] d;
        begin
            d = signed'({2'b00, now}) - signed'({2'b00, prev});
            if (prev >= JWRD_TICK_HIGH && now <= JWRD_TICK_LOW)
            begin
                d = d + JWRD_TICK_SPAN;
            end
            else if (prev <= JWRD_TICK_LOW && now >= JWRD_TICK_HIGH)
            begin
                d = d - JWRD_TICK_SPAN;
            end
            return d;
        end
    endfunction

endpackage

// ===== hdl/jwrd_front.sv =====
// Front end: counts report bytes, captures the fields of interest and pushes one
// record per report of at least the minimum length. Depends on jwrd_pkg.
module jwrd_front
    import jwrd_pkg::*;
#(
    parameter int unsigned MAX_REPORT_BYTES = JWRD_MAX_REPORT_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] report_byte,
    input  logic       report_end,
    input  logic       q_not_full,
    output logic       q_push,
    output jwrd_rec_t  q_wdata
);

    localparam int unsigned PW = $clog2(MAX_REPORT_BYTES + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic          short_reg, short_next;
    logic [7:0]    tick_l_reg, tick_l_next;
    logic [7:0]    tick_r_reg, tick_r_next;
    logic [7:0]    flo_reg, flo_next;
    logic [7:0]    fhi_reg, fhi_next;
    logic          play_a_reg, play_a_next;
    logic          play_b_reg, play_b_next;
    logic [1:0]    touch_reg, touch_next;
    logic          accept;

    assign in_ready = q_not_full;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        pos_next    = pos_reg;
        short_next  = short_reg;
        tick_l_next = tick_l_reg;
        tick_r_next = tick_r_reg;
        flo_next    = flo_reg;
        fhi_next    = fhi_reg;
        play_a_next = play_a_reg;
        play_b_next = play_b_reg;
        touch_next  = touch_reg;
        if (accept)
        begin
            // report start: bytes not yet seen read as zero
            if (pos_reg == '0)
            begin
                short_next  = 1'b0;
                tick_l_next = '0;
                tick_r_next = '0;
                flo_next    = '0;
                fhi_next    = '0;
                play_a_next = 1'b0;
                play_b_next = 1'b0;
                touch_next  = '0;
            end
            if (pos_reg == PW'(JWRD_OFF_ID))       short_next  = (report_byte == JWRD_SHORT_ID);
            if (pos_reg == PW'(JWRD_OFF_TICK_L))   tick_l_next = report_byte;
            if (pos_reg == PW'(JWRD_OFF_TICK_R))   tick_r_next = report_byte;
            if (pos_reg == PW'(JWRD_OFF_FADER_LO)) flo_next    = report_byte;
            if (pos_reg == PW'(JWRD_OFF_FADER_HI)) fhi_next    = report_byte;
            if (pos_reg == PW'(JWRD_OFF_PLAY_A))   play_a_next = report_byte[0];
            if (pos_reg == PW'(JWRD_OFF_PLAY_B))   play_b_next = report_byte[0];
            if (pos_reg == PW'(JWRD_OFF_TOUCH))    touch_next  = report_byte[1:0];

            if (report_end)
            begin
                pos_next = '0;
            end
            else if (pos_reg < PW'(MAX_REPORT_BYTES))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    assign q_push = accept && report_end && (pos_reg >= PW'(JWRD_MIN_REPORT_LEN - 1));

    always_comb
    begin
        q_wdata.short_rpt  = short_next;
        q_wdata.tick_l     = tick_l_next;
        q_wdata.tick_r     = tick_r_next;
        q_wdata.fader_word = {fhi_next, flo_next};
        q_wdata.start      = play_a_next | play_b_next;
        q_wdata.touch      = touch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        short_reg  <= short_next;
        tick_l_reg <= tick_l_next;
        tick_r_reg <= tick_r_next;
        flo_reg    <= flo_next;
        fhi_reg    <= fhi_next;
        play_a_reg <= play_a_next;
        play_b_reg <= play_b_next;
        touch_reg  <= touch_next;
    end

endmodule

// ===== hdl/jwrd_fifo.sv =====
// Short record queue between front and back ends.
// Depends on jwrd_pkg for the record type.
module jwrd_fifo
    import jwrd_pkg::*;
#(
    parameter int unsigned DEPTH = JWRD_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  jwrd_rec_t wdata,
    input  logic      pop,
    output jwrd_rec_t rdata,
    output logic      not_empty,
    output logic      not_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    jwrd_rec_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CW'(DEPTH));
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/jwrd_back.sv =====
// Back end: applies queued report records to the wheel totals, flags and fader,
// and holds the result beat until taken. Depends on jwrd_pkg.
module jwrd_back
    import jwrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  jwrd_rec_t          q_rdata,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               report_kind,
    output logic signed [31:0] left_jog_total,
    output logic signed [31:0] right_jog_total,
    output logic               left_touched,
    output logic               right_touched,
    output logic               start_pressed,
    output logic signed [15:0] crossfader
);

    logic               valid_reg, valid_next;
    logic               kind_reg, kind_next;
    logic [7:0]         prev_l_reg, prev_l_next;
    logic [7:0]         prev_r_reg, prev_r_next;
    logic signed [31:0] total_l_reg, total_l_next;
    logic signed [31:0] total_r_reg, total_r_next;
    logic [1:0]         touch_reg, touch_next;
    logic               start_reg, start_next;
    logic [15:0]        fader_reg, fader_next;
    logic signed [9:0]  delta_l, delta_r;

    assign q_pop   = q_not_empty && (!valid_reg || out_ready);
    assign delta_l = jwrd_tick_delta(prev_l_reg, q_rdata.tick_l);
    assign delta_r = jwrd_tick_delta(prev_r_reg, q_rdata.tick_r);

    always_comb
    begin
        valid_next   = valid_reg;
        kind_next    = kind_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        total_l_next = total_l_reg;
        total_r_next = total_r_reg;
        touch_next   = touch_reg;
        start_next   = start_reg;
        fader_next   = fader_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (q_pop)
        begin
            valid_next = 1'b1;
            if (q_rdata.short_rpt)
            begin
                kind_next    = JWRD_KIND_SHORT;
                prev_l_next  = q_rdata.tick_l;
                prev_r_next  = q_rdata.tick_r;
                total_l_next = total_l_reg + 32'(delta_l);
                total_r_next = total_r_reg + 32'(delta_r);
                touch_next   = q_rdata.touch;
                start_next   = q_rdata.start;
            end
            else
            begin
                kind_next  = JWRD_KIND_LONG;
                fader_next = q_rdata.fader_word - JWRD_FADER_BIAS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            kind_reg    <= JWRD_KIND_SHORT;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            total_l_reg <= '0;
            total_r_reg <= '0;
            touch_reg   <= '0;
            start_reg   <= 1'b0;
            fader_reg   <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            kind_reg    <= kind_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            total_l_reg <= total_l_next;
            total_r_reg <= total_r_next;
            touch_reg   <= touch_next;
            start_reg   <= start_next;
            fader_reg   <= fader_next;
        end
    end

    assign out_valid       = valid_reg;
    assign report_kind     = kind_reg;
    assign left_jog_total  = total_l_reg;
    assign right_jog_total = total_r_reg;
    assign left_touched    = touch_reg[0];
    assign right_touched   = touch_reg[1];
    assign start_pressed   = start_reg;
    assign crossfader      = signed'(fader_reg);

endmodule

// ===== hdl/jog_wheel_report_decoder_core.sv =====
// Top level of the jog wheel report decoder: front end, record queue, back end.
// Depends on jwrd_pkg, jwrd_front, jwrd_fifo and jwrd_back.
//
// Takes one report byte per cycle on the input channel, with report_end on the
// last beat. Each report of 10 bytes or more yields one result beat carrying all
// held values; shorter reports yield nothing. The record enters the queue at the
// edge that takes the last byte and moves into the back end's output register
// once that register is empty or its beat is being taken. Input is stalled only
// when the queue (QUEUE_DEPTH records) is full because results are not being
// taken.
module jog_wheel_report_decoder_core
    import jwrd_pkg::*;
#(
    parameter int unsigned MAX_REPORT_BYTES = JWRD_MAX_REPORT_BYTES,
    parameter int unsigned QUEUE_DEPTH      = JWRD_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         report_byte,
    input  logic               report_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               report_kind,
    output logic signed [31:0] left_jog_total,
    output logic signed [31:0] right_jog_total,
    output logic               left_touched,
    output logic               right_touched,
    output logic               start_pressed,
    output logic signed [15:0] crossfader
);

    logic      q_push;
    logic      q_pop;
    logic      q_not_full;
    logic      q_not_empty;
    jwrd_rec_t q_wdata;
    jwrd_rec_t q_rdata;

    jwrd_front #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .report_byte (report_byte),
        .report_end  (report_end),
        .q_not_full  (q_not_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    jwrd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    jwrd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .report_kind     (report_kind),
        .left_jog_total  (left_jog_total),
        .right_jog_total (right_jog_total),
        .left_touched    (left_touched),
        .right_touched   (right_touched),
        .start_pressed   (start_pressed),
        .crossfader      (crossfader)
    );

endmodule
